FILE: rtl/kmsd_pkg.sv
package kmsd_pkg;

    localparam int COL_W     = 3;
    localparam int TIME_W    = 32;
    localparam int QRY_W     = 2;
    localparam int ROW_OUT_W = 2;
    localparam int MAP_W     = 9;
    localparam int DEB_W     = 8;

    localparam logic [DEB_W-1:0] DEB_RESET = 8'd5;

    typedef struct packed {
        logic [COL_W-1:0]  col_levels;
        logic [TIME_W-1:0] time_ms;
        logic [QRY_W-1:0]  query_row;
        logic [QRY_W-1:0]  query_col;
    } t_in_item;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] scanned_row;
        logic [COL_W-1:0]     row_keys;
        logic [MAP_W-1:0]     key_map;
        logic                 any_pressed;
        logic                 query_pressed;
        logic [ROW_OUT_W-1:0] next_row_drive;
    } t_out_item;

endpackage

FILE: rtl/kmsd_row_mem.sv
module kmsd_row_mem #(
    parameter int WIDTH = 99,
    parameter int DEPTH = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_raw;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp;
    logic             r_rd_valid;
    logic [DEPTH-1:0] r_valid;
    logic             n_same;

    assign n_same = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // rows never written read as zero; a write to the row being read is passed through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_byp      <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_byp      <= n_same;
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        if (r_byp) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

FILE: rtl/kmsd_key_update.sv
module kmsd_key_update #(
    parameter int NUM_COLS = 3
) (
    input  kmsd_pkg::t_in_item                    i_item,
    input  logic [kmsd_pkg::DEB_W-1:0]            i_debounce_ms,
    input  logic [NUM_COLS*(1+kmsd_pkg::TIME_W)-1:0] i_entry,
    input  logic [NUM_COLS-1:0]                   i_deb_row,
    output logic [NUM_COLS*(1+kmsd_pkg::TIME_W)-1:0] o_entry,
    output logic [NUM_COLS-1:0]                   o_deb_row
);
    import kmsd_pkg::*;

    logic [NUM_COLS-1:0] levels;
    logic [NUM_COLS-1:0] raw;
    logic [TIME_W-1:0]   elapsed [NUM_COLS];

    // columns beyond the input field read low, i.e. pressed
    assign levels = NUM_COLS'(i_item.col_levels);
    assign raw    = ~levels;

    // entry layout: previous raw bits low, then one change time per column
    always_comb begin
        o_entry   = i_entry;
        o_deb_row = i_deb_row;
        for (int c = 0; c < NUM_COLS; c++) begin
            elapsed[c] = i_item.time_ms - i_entry[NUM_COLS + c*TIME_W +: TIME_W];
            if (raw[c] != i_entry[c]) begin
                o_entry[c] = raw[c];
                o_entry[NUM_COLS + c*TIME_W +: TIME_W] = i_item.time_ms;
            end else if (elapsed[c] > TIME_W'(i_debounce_ms)) begin
                o_deb_row[c] = raw[c];
            end
        end
    end

endmodule

FILE: rtl/key_matrix_scan_debounce_unit.sv
// Key matrix scanner with per-key debounce. Each input transaction is one scan step for the
// row currently driven low; one result transaction follows for each, in order. Steps are
// accepted one per clock cycle while the output is not stalled, and a result is valid once
// its step has passed the stage-1 and result registers: the accepting edge reads the row's
// raw samples and change times from the row memory, and the stage-1 step compares them,
// writes the row back and loads the result register once the output is free. A write to
// the row being read in the same cycle is bypassed into the read data, so back-to-back
// steps on the same row (a single-row matrix) keep full rate. Debounced key states sit in
// flip-flops so the whole key map is available every cycle. No clearing pass after reset.
module key_matrix_scan_debounce_unit #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  kmsd_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output kmsd_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kmsd_pkg::DEB_W-1:0]    i_cfg_data
);
    import kmsd_pkg::*;

    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
    localparam int RW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int EW       = NUM_COLS * (1 + TIME_W);

    logic [DEB_W-1:0]    r_debounce_ms;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       n_row;
    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic [RW-1:0]       r_s1_row;
    logic [NUM_KEYS-1:0] r_deb;
    logic [NUM_KEYS-1:0] n_deb;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           n_out;

    logic                accept;
    logic                s1_adv;
    logic [EW-1:0]       rd_entry;
    logic [EW-1:0]       wr_entry;
    logic [NUM_COLS-1:0] deb_row_old;
    logic [NUM_COLS-1:0] deb_row_new;
    logic [RW-1:0]       s1_next_row;
    logic [KW-1:0]       q_idx;
    logic                q_in_range;

    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign accept      = i_in_valid && !o_in_stall;
    assign n_row       = (r_row == RW'(NUM_ROWS - 1)) ? '0 : r_row + 1'b1;
    assign s1_next_row = (r_s1_row == RW'(NUM_ROWS - 1)) ? '0 : r_s1_row + 1'b1;

    kmsd_row_mem #(
        .WIDTH (EW),
        .DEPTH (NUM_ROWS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_row),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_row),
        .i_wr_data (wr_entry),
        .o_rd_data (rd_entry)
    );

    assign deb_row_old = r_deb[r_s1_row*NUM_COLS +: NUM_COLS];

    kmsd_key_update #(
        .NUM_COLS (NUM_COLS)
    ) u_key_update (
        .i_item        (r_s1_item),
        .i_debounce_ms (r_debounce_ms),
        .i_entry       (rd_entry),
        .i_deb_row     (deb_row_old),
        .o_entry       (wr_entry),
        .o_deb_row     (deb_row_new)
    );

    assign q_in_range = (32'(r_s1_item.query_row) < NUM_ROWS)
                     && (32'(r_s1_item.query_col) < NUM_COLS);
    assign q_idx      = KW'(r_s1_item.query_row) * KW'(NUM_COLS) + KW'(r_s1_item.query_col);

    always_comb begin
        n_deb = r_deb;
        n_deb[r_s1_row*NUM_COLS +: NUM_COLS] = deb_row_new;

        n_out = '0;
        n_out.scanned_row    = ROW_OUT_W'(r_s1_row);
        n_out.next_row_drive = ROW_OUT_W'(s1_next_row);
        for (int c = 0; c < COL_W; c++) begin
            if (c < NUM_COLS) begin
                n_out.row_keys[c] = deb_row_new[c];
            end
        end
        for (int k = 0; k < MAP_W; k++) begin
            if (k < NUM_KEYS) begin
                n_out.key_map[k] = n_deb[k];
            end
        end
        n_out.any_pressed   = |n_deb;
        n_out.query_pressed = q_in_range && n_deb[q_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEB_RESET;
            r_row         <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_deb         <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_debounce_ms <= i_cfg_data;
            end
            if (accept) begin
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_deb       <= n_deb;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_data;
            r_s1_row  <= r_row;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/kmsd_checker.sv
module kmsd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input kmsd_pkg::t_out_item        o_out_data
);
    import kmsd_pkg::*;

    logic [ROW_OUT_W-1:0] r_exp_row;

    // row each result should report: the drive row announced by the one before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_exp_row <= o_out_data.next_row_drive;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_row_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.scanned_row == r_exp_row)
        else $error("scanned row out of sequence");

    a_any_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.key_map != '0) |-> o_out_data.any_pressed)
        else $error("key map set but no key reported pressed");

    a_row_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.row_keys != '0) |-> o_out_data.any_pressed)
        else $error("row key set but no key reported pressed");

endmodule

bind key_matrix_scan_debounce_unit kmsd_checker u_kmsd_checker (.*);

FILE: bench/key_scan_checker.sv
`timescale 1ns / 1ps

module key_scan_checker #(
    parameter int NUM_ROWS = 3,
    parameter int NUM_COLS = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  kmsd_pkg::t_in_item         i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  kmsd_pkg::t_out_item        i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [kmsd_pkg::DEB_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import kmsd_pkg::*;

    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;

    logic [DEB_W-1:0]  debounce_ms;
    logic              raw_seen   [NUM_KEYS];
    logic              key_state  [NUM_KEYS];
    logic [TIME_W-1:0] changed_at [NUM_KEYS];
    int unsigned       drive_row;
    t_out_item         expected_scans[$];
    t_out_item         want;
    int                mismatches = 0;

    assign o_fail_count = mismatches;

    // One scan step: sample the driven row, update timers and debounced keys.
    function automatic t_out_item scan_row_step(t_in_item step);
        t_out_item         res;
        logic [TIME_W-1:0] elapsed;
        logic              raw;
        int                idx;
        res = '0;
        for (int c = 0; c < NUM_COLS; c++) begin
            idx = drive_row * NUM_COLS + c;
            raw = ~step.col_levels[c];
            if (raw != raw_seen[idx]) begin
                raw_seen[idx]   = raw;
                changed_at[idx] = step.time_ms;
            end
            elapsed = step.time_ms - changed_at[idx];
            if (elapsed > TIME_W'(debounce_ms))
                key_state[idx] = raw;
            if (c < COL_W)
                res.row_keys[c] = key_state[idx];
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (key_state[k])
                res.any_pressed = 1'b1;
            if (k < MAP_W)
                res.key_map[k] = key_state[k];
        end
        if (step.query_row < NUM_ROWS && step.query_col < NUM_COLS)
            res.query_pressed = key_state[step.query_row * NUM_COLS + step.query_col];
        res.scanned_row    = ROW_OUT_W'(drive_row);
        drive_row          = (drive_row + 1) % NUM_ROWS;
        res.next_row_drive = ROW_OUT_W'(drive_row);
        return res;
    endfunction

    task automatic check_field(string field, longint unsigned exp_val, longint unsigned act_val);
        if (exp_val != act_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, field, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce_ms = DEB_RESET;
            drive_row   = 0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                raw_seen[k]   = 1'b0;
                key_state[k]  = 1'b0;
                changed_at[k] = '0;
            end
            expected_scans.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                debounce_ms = i_cfg_data;
            // compare before pushing so a result can never match its own step
            if (i_out_valid && !i_out_stall) begin
                if (expected_scans.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transaction with nothing expected: 0x%0h",
                                 $realtime, i_out_data);
                end else begin
                    want = expected_scans.pop_front();
                    check_field("scanned_row", want.scanned_row, i_out_data.scanned_row);
                    check_field("row_keys", want.row_keys, i_out_data.row_keys);
                    check_field("key_map", want.key_map, i_out_data.key_map);
                    check_field("any_pressed", want.any_pressed, i_out_data.any_pressed);
                    check_field("query_pressed", want.query_pressed,
                                i_out_data.query_pressed);
                    check_field("next_row_drive", want.next_row_drive,
                                i_out_data.next_row_drive);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_scans.push_back(scan_row_step(i_in_data));
        end
        o_pending <= expected_scans.size();
    end

endmodule

FILE: bench/key_matrix_scan_debounce_unit_tb.sv
`timescale 1ns / 1ps

module key_matrix_scan_debounce_unit_tb;
    import kmsd_pkg::*;

    localparam int ROWS        = 3;
    localparam int PHASES      = 6;
    localparam int PHASE_STEPS = 225;
    localparam int CYCLE_LIMIT = 200000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [DEB_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    logic             cfg_ready;
    t_out_item        out_data;
    int               fail_count;
    int               pending;

    bit                quiet        = 1'b0;
    logic [TIME_W-1:0] now_ms       = '0;
    logic [COL_W-1:0]  held_levels [ROWS];
    logic [DEB_W-1:0]  debounce_now = DEB_RESET;
    logic [DEB_W-1:0]  plan [PHASES];
    int                steps_sent   = 0;
    int                cycles       = 0;

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 24);

    key_matrix_scan_debounce_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    key_scan_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // random idle gaps before about one step in eleven: roughly a quarter idle
    task automatic send_step(input logic [COL_W-1:0] levels, input logic [TIME_W-1:0] stamp,
                             input logic [QRY_W-1:0] qrow, input logic [QRY_W-1:0] qcol);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'{col_levels: levels, time_ms: stamp,
                               query_row: qrow, query_col: qcol};
        do @(posedge clk); while (in_stall);
        steps_sent++;
    endtask

    // Held pattern per row with occasional changes, contact bounce and pure noise.
    task automatic random_step();
        logic [COL_W-1:0] levels;
        int               row;
        int               span;
        int               roll;
        row = steps_sent % ROWS;
        if ($urandom_range(0, 99) < 8)
            held_levels[row] = COL_W'($urandom_range(0, 7));
        levels = held_levels[row];
        roll   = $urandom_range(0, 99);
        if (roll < 10)
            levels = COL_W'($urandom_range(0, 7));
        else if (roll < 20)
            levels = levels ^ (COL_W'(1) << $urandom_range(0, 2));
        span = int'(debounce_now) / 3 + 2;
        if ($urandom_range(0, 99) < 2)
            now_ms = $urandom();
        else
            now_ms = now_ms + TIME_W'($urandom_range(0, span));
        send_step(levels, now_ms, QRY_W'($urandom_range(0, 3)), QRY_W'($urandom_range(0, 3)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_debounce(input logic [DEB_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        debounce_now = value;
    endtask

    initial begin
        for (int r = 0; r < ROWS; r++)
            held_levels[r] = '1;
        plan = '{DEB_RESET, 8'd0, 8'd255, 8'd1, 8'd0, 8'd128};
        plan[4] = DEB_W'($urandom_range(2, 254));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // debounce 5 from reset: threshold is strictly greater
        send_step(3'b000, 32'd0, 2'd0, 2'd0);
        send_step(3'b111, 32'd0, 2'd3, 2'd3);
        send_step(3'b010, 32'd1, 2'd2, 2'd2);
        send_step(3'b000, 32'd5, 2'd0, 2'd0);
        send_step(3'b111, 32'd5, 2'd0, 2'd3);
        send_step(3'b010, 32'd6, 2'd3, 2'd0);
        send_step(3'b000, 32'd6, 2'd0, 2'd1);
        send_step(3'b111, 32'd7, 2'd1, 2'd1);
        send_step(3'b010, 32'd7, 2'd2, 2'd0);
        send_step(3'b110, 32'd7, 2'd0, 2'd0);
        // time wrapping through zero
        send_step(3'b000, 32'hFFFF_FFFA, 2'd1, 2'd2);
        send_step(3'b111, 32'hFFFF_FFFA, 2'd2, 2'd2);
        send_step(3'b110, 32'hFFFF_FFFF, 2'd0, 2'd2);
        send_step(3'b000, 32'h0000_0000, 2'd1, 2'd0);
        send_step(3'b111, 32'h0000_0001, 2'd2, 2'd1);
        send_step(3'b111, 32'h0000_0002, 2'd3, 2'd2);
        send_step(3'b101, 32'h8000_0000, 2'd1, 2'd3);
        send_step(3'b000, 32'h8000_0000, 2'd2, 2'd1);
        now_ms = 32'h8000_0000;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0)
                set_debounce(plan[p]);
            quiet = (p == 3);
            repeat (PHASE_STEPS) random_step();
        end
        quiet = 1'b0;
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/kmsd_pkg.sv
rtl/kmsd_row_mem.sv
rtl/kmsd_key_update.sv
rtl/key_matrix_scan_debounce_unit.sv
rtl/kmsd_checker.sv
bench/key_scan_checker.sv
bench/key_matrix_scan_debounce_unit_tb.sv
